// File: rtl/blarc_pkg.sv
`timescale 1ns / 1ps
package blarc_pkg;

   localparam int CMD_W   = 2;
   localparam int STATE_W = 12;
   localparam int START_W = 15;
   localparam int SLOT_W  = 14;
   localparam int LABEL_W = 16;
   localparam int WT_W    = 32;
   localparam int STEPS_W = 4;
   localparam int POS_W   = 15;
   localparam int NARC_W  = 15;
   localparam int NST_W   = 13;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_STATE = 2'd0,
      CMD_ARC   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_ARCS   = 1'b0,
      REG_STATES = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic load_state;
      logic load_arc;
      logic load_query;
      logic rd_cur;
      logic rd_k;
      logic take_start;
      logic scan_hit;
      logic scan_step;
      logic init_search;
      logic rd_mid;
      logic search_step;
      logic rd_lo;
      logic rd_base;
      logic take_backoff;
      logic finish_found;
      logic finish_miss;
      logic finish_err;
   } ctl_cmd_type;

   typedef struct packed {
      logic label_zero;
      logic cur_out;
      logic start_neg;
      logic k_out;
      logic scan_nonneg;
      logic run_empty;
      logic cnt_zero;
      logic hit;
      logic base_backoff;
      logic steps_at_max;
   } ctl_stat_type;

endpackage

// File: rtl/blarc_csr.sv
`timescale 1ns / 1ps
module blarc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [blarc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [blarc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [blarc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                         csr_pready,
   output logic [blarc_pkg::NARC_W-1:0] arcs_in_use,
   output logic [blarc_pkg::NST_W-1:0]  states_in_use
);
   import blarc_pkg::*;

   logic [NARC_W-1:0] arcs_ff, arcs_in;
   logic [NST_W-1:0]  states_ff, states_in;
   logic              wr_en;
   reg_index_type     idx;

   assign idx        = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      arcs_in   = arcs_ff;
      states_in = states_ff;
      if (wr_en) begin
         case (idx)
            REG_ARCS:   arcs_in   = csr_pwdata[NARC_W-1:0];
            REG_STATES: states_in = csr_pwdata[NST_W-1:0];
            default:    arcs_in   = arcs_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ARCS:   csr_prdata = CSR_DW'(arcs_ff);
         REG_STATES: csr_prdata = CSR_DW'(states_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arcs_ff   <= '0;
         states_ff <= '0;
      end else begin
         arcs_ff   <= arcs_in;
         states_ff <= states_in;
      end
   end

   assign arcs_in_use   = arcs_ff;
   assign states_in_use = states_ff;
endmodule

// File: rtl/blarc_ctrl.sv
`timescale 1ns / 1ps
module blarc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [blarc_pkg::CMD_W-1:0] req_cmd,
   input  blarc_pkg::ctl_stat_type     stat,
   output blarc_pkg::ctl_cmd_type      cmd,
   output logic                        busy
);
   import blarc_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_RUN_RD    = 11'b00000000010,
      S_RUN_WAIT  = 11'b00000000100,
      S_SCAN_RD   = 11'b00000001000,
      S_SCAN_WAIT = 11'b00000010000,
      S_CLIP      = 11'b00000100000,
      S_SRCH      = 11'b00001000000,
      S_SRCH_WAIT = 11'b00010000000,
      S_LO_WAIT   = 11'b00100000000,
      S_BASE_RD   = 11'b01000000000,
      S_BASE_WAIT = 11'b10000000000
   } fsm_type;

   fsm_type state_ff, state_in;
   logic    accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start & ~busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_STATE: cmd.load_state = 1'b1;
                  CMD_ARC:   cmd.load_arc   = 1'b1;
                  CMD_QUERY: begin
                     cmd.load_query = 1'b1;
                     if (stat.label_zero) cmd.finish_err = 1'b1;
                     else state_in = S_RUN_RD;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         S_RUN_RD: begin
            if (stat.cur_out) begin
               cmd.finish_miss = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in = S_RUN_WAIT;
            end
         end
         S_RUN_WAIT: begin
            if (stat.start_neg) begin
               cmd.finish_miss = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.take_start = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.k_out) state_in = S_CLIP;
            else begin
               cmd.rd_k = 1'b1;
               state_in = S_SCAN_WAIT;
            end
         end
         S_SCAN_WAIT: begin
            if (stat.scan_nonneg) begin
               cmd.scan_hit = 1'b1;
               state_in = S_CLIP;
            end else begin
               cmd.scan_step = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_CLIP: begin
            if (stat.run_empty) begin
               cmd.finish_miss = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.init_search = 1'b1;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (stat.cnt_zero) begin
               cmd.rd_lo = 1'b1;
               state_in = S_LO_WAIT;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in = S_SRCH_WAIT;
            end
         end
         S_SRCH_WAIT: begin
            cmd.search_step = 1'b1;
            state_in = S_SRCH;
         end
         S_LO_WAIT: begin
            if (stat.hit) begin
               cmd.finish_found = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_BASE_RD;
         end
         S_BASE_RD: begin
            cmd.rd_base = 1'b1;
            state_in = S_BASE_WAIT;
         end
         S_BASE_WAIT: begin
            if (!stat.base_backoff) begin
               cmd.finish_miss = 1'b1;
               state_in = S_IDLE;
            end else if (stat.steps_at_max) begin
               cmd.finish_err = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.take_backoff = 1'b1;
               state_in = S_RUN_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_finish_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.finish_found, cmd.finish_miss, cmd.finish_err}))
      else $error("more than one finish");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish_found || cmd.finish_miss || cmd.finish_err) |=> !busy)
      else $error("busy after finish");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_state || cmd.load_arc || cmd.load_query) |-> !busy)
      else $error("load while busy");
   a_backoff_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.take_backoff |-> !stat.steps_at_max)
      else $error("backoff past limit");
endmodule

// File: rtl/blarc_dpath.sv
`timescale 1ns / 1ps
module blarc_dpath #(
   parameter int MAX_STATES  = 4096,
   parameter int MAX_ARCS    = 16384,
   parameter int MAX_BACKOFF = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  blarc_pkg::ctl_cmd_type        cmd,
   output blarc_pkg::ctl_stat_type       stat,
   input  logic [blarc_pkg::STATE_W-1:0] req_state,
   input  logic signed [blarc_pkg::START_W-1:0] req_arc_start,
   input  logic [blarc_pkg::SLOT_W-1:0]  req_arc_slot,
   input  logic [blarc_pkg::STATE_W-1:0] req_next_state,
   input  logic [blarc_pkg::LABEL_W-1:0] req_in_label,
   input  logic [blarc_pkg::LABEL_W-1:0] req_out_label,
   input  logic signed [blarc_pkg::WT_W-1:0] req_weight,
   input  logic [blarc_pkg::NARC_W-1:0]  arcs_in_use,
   input  logic [blarc_pkg::NST_W-1:0]   states_in_use,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [blarc_pkg::STATE_W-1:0] rsp_dest_state,
   output logic [blarc_pkg::LABEL_W-1:0] rsp_found_out_label,
   output logic signed [blarc_pkg::WT_W-1:0] rsp_total_weight,
   output logic [blarc_pkg::STEPS_W-1:0] rsp_backoff_steps,
   output logic                          rsp_query_error
);
   import blarc_pkg::*;

   localparam int SAW  = $clog2(MAX_STATES);
   localparam int AAW  = $clog2(MAX_ARCS);
   localparam int SCW  = $clog2(MAX_BACKOFF + 1);
   localparam int ACCW = WT_W + 1 + SCW;
   localparam int KEYW = LABEL_W + STATE_W;
   localparam int PAYW = LABEL_W + WT_W;

   logic [START_W-1:0] fa_mem [MAX_STATES];
   logic [KEYW-1:0]    key_mem [MAX_ARCS];
   logic [PAYW-1:0]    pay_mem [MAX_ARCS];

   logic [START_W-1:0] fa_q_ff;
   logic [KEYW-1:0]    key_q_ff;
   logic [PAYW-1:0]    pay_q_ff;

   logic [LABEL_W-1:0] label_ff;
   logic [STATE_W-1:0] cur_ff;
   logic [POS_W-1:0]   start_ff, end_ff, lo_ff, hi_ff, cnt_ff;
   logic [NST_W-1:0]   k_ff;
   logic [SCW-1:0]     steps_ff;
   logic signed [ACCW-1:0] acc_ff;

   logic                   rsp_valid_ff, rsp_found_ff, rsp_err_ff;
   logic [STATE_W-1:0]     rsp_dest_ff;
   logic [LABEL_W-1:0]     rsp_olabel_ff;
   logic [WT_W-1:0]        rsp_wt_ff;
   logic [STEPS_W-1:0]     rsp_steps_ff;

   logic [NST_W-1:0]       lim;
   logic [POS_W-1:0]       clip_end, half, mid, key_addr;
   logic [LABEL_W-1:0]     key_label;
   logic [STATE_W-1:0]     key_dest;
   logic [LABEL_W-1:0]     pay_olabel;
   logic signed [WT_W-1:0] pay_wt;
   logic signed [ACCW-1:0] sum;
   logic [WT_W-1:0]        sat;
   logic                   wr_state, wr_arc;

   assign lim = (32'(states_in_use) < MAX_STATES) ? states_in_use : NST_W'(MAX_STATES);
   assign clip_end = (32'(end_ff) > MAX_ARCS) ? POS_W'(MAX_ARCS) : end_ff;
   assign half = cnt_ff >> 1;
   assign mid = lo_ff + half;
   assign key_label = key_q_ff[KEYW-1:STATE_W];
   assign key_dest = key_q_ff[STATE_W-1:0];
   assign pay_olabel = pay_q_ff[PAYW-1:WT_W];
   assign pay_wt = signed'(pay_q_ff[WT_W-1:0]);
   assign sum = acc_ff + ACCW'(pay_wt);
   assign sat = (sum[ACCW-1:WT_W-1] == '0 || sum[ACCW-1:WT_W-1] == '1) ? sum[WT_W-1:0]
              : (sum[ACCW-1] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}});

   assign wr_state = cmd.load_state && (32'(req_state) < MAX_STATES);
   assign wr_arc   = cmd.load_arc && (32'(req_arc_slot) < MAX_ARCS);

   always_comb begin
      key_addr = lo_ff;
      if (cmd.rd_mid) key_addr = mid;
      else if (cmd.rd_base) key_addr = start_ff;
   end

   assign stat.label_zero   = (req_in_label == '0);
   assign stat.cur_out      = ({1'b0, cur_ff} >= lim);
   assign stat.start_neg    = fa_q_ff[START_W-1];
   assign stat.k_out        = (k_ff >= lim);
   assign stat.scan_nonneg  = ~fa_q_ff[START_W-1];
   assign stat.run_empty    = (start_ff >= clip_end);
   assign stat.cnt_zero     = (cnt_ff == '0);
   assign stat.hit          = (lo_ff < hi_ff) && (key_label == label_ff);
   assign stat.base_backoff = (key_label == '0);
   assign stat.steps_at_max = (32'(steps_ff) >= MAX_BACKOFF);

   always_ff @(posedge clock) begin
      if (wr_state) fa_mem[SAW'(req_state)] <= req_arc_start;
      if (cmd.rd_cur) fa_q_ff <= fa_mem[SAW'(cur_ff)];
      else if (cmd.rd_k) fa_q_ff <= fa_mem[SAW'(k_ff)];
   end

   always_ff @(posedge clock) begin
      if (wr_arc) begin
         key_mem[AAW'(req_arc_slot)] <= {req_in_label, req_next_state};
         pay_mem[AAW'(req_arc_slot)] <= {req_out_label, req_weight};
      end
      if (cmd.rd_mid || cmd.rd_lo || cmd.rd_base) begin
         key_q_ff <= key_mem[AAW'(key_addr)];
         pay_q_ff <= pay_mem[AAW'(key_addr)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         label_ff <= req_in_label;
         cur_ff   <= req_state;
         steps_ff <= '0;
         acc_ff   <= '0;
      end
      if (cmd.take_start) begin
         start_ff <= fa_q_ff;
         k_ff     <= NST_W'(cur_ff) + 1'b1;
         end_ff   <= POS_W'(arcs_in_use);
      end
      if (cmd.scan_hit) end_ff <= fa_q_ff;
      if (cmd.scan_step) k_ff <= k_ff + 1'b1;
      if (cmd.init_search) begin
         lo_ff  <= start_ff;
         hi_ff  <= clip_end;
         cnt_ff <= clip_end - start_ff;
      end
      if (cmd.search_step) begin
         if (key_label < label_ff) begin
            lo_ff  <= mid + 1'b1;
            cnt_ff <= cnt_ff - half - 1'b1;
         end else begin
            cnt_ff <= half;
         end
      end
      if (cmd.take_backoff) begin
         acc_ff   <= sum;
         steps_ff <= steps_ff + 1'b1;
         cur_ff   <= key_dest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish_found | cmd.finish_miss | cmd.finish_err;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_found || cmd.finish_miss || cmd.finish_err) begin
         rsp_found_ff  <= cmd.finish_found;
         rsp_err_ff    <= cmd.finish_err;
         rsp_steps_ff  <= cmd.load_query ? '0 : STEPS_W'(steps_ff);
         rsp_dest_ff   <= cmd.finish_found ? key_dest : '0;
         rsp_olabel_ff <= cmd.finish_found ? pay_olabel : '0;
         rsp_wt_ff     <= cmd.finish_found ? sat : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_dest_state      = rsp_dest_ff;
   assign rsp_found_out_label = rsp_olabel_ff;
   assign rsp_total_weight    = signed'(rsp_wt_ff);
   assign rsp_backoff_steps   = rsp_steps_ff;
   assign rsp_query_error     = rsp_err_ff;
endmodule

// File: rtl/backoff_lm_arc_lookup_top.sv
`timescale 1ns / 1ps
// Backoff arc lookup over a transducer graph held in three on-chip tables
// (per-state first arc, arc keys, arc payloads), each with one registered read
// port; the tables are undefined until loaded and get no clearing pass. Load
// commands (write state start, write arc) give no item. For each state visited, a
// query reads its start, then scans the following states' starts to find the run
// end (until the scan runs out of states), forms the run, runs the binary-search
// probes (about log2 of the run length, plus one), does the final compare and, on a
// miss, checks for a backoff arc; the result item is registered after the last of
// these. A label-zero query is answered with an error item straight from idle.
// busy is high while a query runs.
// Each result item appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall it and must take it then.
module backoff_lm_arc_lookup_top #(
   parameter int MAX_STATES  = 4096,
   parameter int MAX_ARCS    = 16384,
   parameter int MAX_BACKOFF = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [blarc_pkg::CMD_W-1:0]   req_cmd,
   input  logic [blarc_pkg::STATE_W-1:0] req_state,
   input  logic signed [blarc_pkg::START_W-1:0] req_arc_start,
   input  logic [blarc_pkg::SLOT_W-1:0]  req_arc_slot,
   input  logic [blarc_pkg::STATE_W-1:0] req_next_state,
   input  logic [blarc_pkg::LABEL_W-1:0] req_in_label,
   input  logic [blarc_pkg::LABEL_W-1:0] req_out_label,
   input  logic signed [blarc_pkg::WT_W-1:0] req_weight,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [blarc_pkg::STATE_W-1:0] rsp_dest_state,
   output logic [blarc_pkg::LABEL_W-1:0] rsp_found_out_label,
   output logic signed [blarc_pkg::WT_W-1:0] rsp_total_weight,
   output logic [blarc_pkg::STEPS_W-1:0] rsp_backoff_steps,
   output logic                          rsp_query_error,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [blarc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [blarc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [blarc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import blarc_pkg::*;

   ctl_cmd_type       cmd;
   ctl_stat_type      stat;
   logic [NARC_W-1:0] arcs_in_use;
   logic [NST_W-1:0]  states_in_use;

   blarc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .arcs_in_use, .states_in_use
   );

   blarc_ctrl u_ctrl (
      .clock, .reset, .start, .req_cmd, .stat, .cmd, .busy
   );

   blarc_dpath #(
      .MAX_STATES(MAX_STATES), .MAX_ARCS(MAX_ARCS), .MAX_BACKOFF(MAX_BACKOFF)
   ) u_dpath (
      .clock, .reset, .cmd, .stat, .req_state, .req_arc_start, .req_arc_slot,
      .req_next_state, .req_in_label, .req_out_label, .req_weight,
      .arcs_in_use, .states_in_use, .rsp_valid, .rsp_found, .rsp_dest_state,
      .rsp_found_out_label, .rsp_total_weight, .rsp_backoff_steps,
      .rsp_query_error
   );
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import blarc_pkg::*;

   localparam int N_STATES   = 4096;
   localparam int N_ARCS     = 16384;
   localparam int N_BACKOFF  = 8;
   localparam int WDOG_LIMIT = 200000;
   localparam logic signed [WT_W-1:0] WT_MAX = 32'sh7fffffff;
   localparam logic signed [WT_W-1:0] WT_MIN = 32'sh80000000;

   typedef struct {
      cmd_type                    cmd;
      logic [STATE_W-1:0]         st;
      logic signed [START_W-1:0]  first;
      logic [SLOT_W-1:0]          slot;
      logic [STATE_W-1:0]         nst;
      logic [LABEL_W-1:0]         lbl;
      logic [LABEL_W-1:0]         olbl;
      logic signed [WT_W-1:0]     wt;
   } arc_item_t;

   typedef struct {
      logic                       found;
      logic [STATE_W-1:0]         dest;
      logic [LABEL_W-1:0]         olbl;
      logic signed [WT_W-1:0]     wt;
      logic [STEPS_W-1:0]         steps;
      logic                       err;
      bit                         undef;
   } arc_hit_t;

   typedef struct {
      arc_item_t                  it;
      bit                         typed;
      arc_hit_t                   want;
   } dir_row_t;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [CMD_W-1:0]          req_cmd;
   logic [STATE_W-1:0]        req_state;
   logic signed [START_W-1:0] req_arc_start;
   logic [SLOT_W-1:0]         req_arc_slot;
   logic [STATE_W-1:0]        req_next_state;
   logic [LABEL_W-1:0]        req_in_label;
   logic [LABEL_W-1:0]        req_out_label;
   logic signed [WT_W-1:0]    req_weight;
   logic                      rsp_valid;
   logic                      rsp_found;
   logic [STATE_W-1:0]        rsp_dest_state;
   logic [LABEL_W-1:0]        rsp_found_out_label;
   logic signed [WT_W-1:0]    rsp_total_weight;
   logic [STEPS_W-1:0]        rsp_backoff_steps;
   logic                      rsp_query_error;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_AW-1:0]         csr_paddr;
   logic [CSR_DW-1:0]         csr_pwdata;
   logic [CSR_DW-1:0]         csr_prdata;
   logic                      csr_pready;

   backoff_lm_arc_lookup_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_state(req_state), .req_arc_start(req_arc_start),
      .req_arc_slot(req_arc_slot), .req_next_state(req_next_state),
      .req_in_label(req_in_label), .req_out_label(req_out_label),
      .req_weight(req_weight),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_dest_state(rsp_dest_state),
      .rsp_found_out_label(rsp_found_out_label), .rsp_total_weight(rsp_total_weight),
      .rsp_backoff_steps(rsp_backoff_steps), .rsp_query_error(rsp_query_error),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // graph mirror
   logic signed [START_W-1:0] first_arc[N_STATES];
   bit                        state_loaded[N_STATES];
   logic [LABEL_W-1:0]        arc_label[N_ARCS];
   logic [STATE_W-1:0]        arc_dest[N_ARCS];
   logic [LABEL_W-1:0]        arc_olabel[N_ARCS];
   logic signed [WT_W-1:0]    arc_weight[N_ARCS];
   bit                        arc_loaded[N_ARCS];
   int unsigned               arcs_n;
   int unsigned               states_n;
   int                        graph_st_base;
   int                        graph_arc_base;

   arc_hit_t  pending_lookups[$];
   dir_row_t  dir_rows[$];
   int        mismatches;
   int        items_sent;
   int        lookups_sent;
   int        idle_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic arc_hit_t predict_lookup(logic [STATE_W-1:0] st0,
                                               logic [LABEL_W-1:0] lbl);
      arc_hit_t res;
      int       lim, cur, k, lo, hi, cnt, half, mid, slot, steps;
      longint   acc;
      res = '{default: 0};
      steps = 0;
      acc = 0;
      if (lbl == 0) begin
         res.err = 1'b1;
         return res;
      end
      lim = (states_n < N_STATES) ? states_n : N_STATES;
      cur = st0;
      while (1) begin
         if (cur >= lim) break;
         if (!state_loaded[cur]) begin
            res.undef = 1;
            return res;
         end
         if (first_arc[cur] < 0) break;
         lo = first_arc[cur];
         hi = arcs_n;
         for (k = cur + 1; k < lim; k++) begin
            if (!state_loaded[k]) begin
               res.undef = 1;
               return res;
            end
            if (first_arc[k] >= 0) begin
               hi = first_arc[k];
               break;
            end
         end
         if (hi > N_ARCS) hi = N_ARCS;
         if (lo >= hi) break;
         slot = lo;
         cnt = hi - lo;
         while (cnt > 0) begin
            half = cnt / 2;
            mid = slot + half;
            if (!arc_loaded[mid]) begin
               res.undef = 1;
               return res;
            end
            if (arc_label[mid] < lbl) begin
               slot = mid + 1;
               cnt -= half + 1;
            end else begin
               cnt = half;
            end
         end
         if (slot < hi) begin
            if (!arc_loaded[slot]) begin
               res.undef = 1;
               return res;
            end
            if (arc_label[slot] == lbl) begin
               acc += arc_weight[slot];
               if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
               if (acc < -64'sh80000000) acc = -64'sh80000000;
               res.found = 1'b1;
               res.dest = arc_dest[slot];
               res.olbl = arc_olabel[slot];
               res.wt = acc[31:0];
               break;
            end
         end
         if (!arc_loaded[lo]) begin
            res.undef = 1;
            return res;
         end
         if (arc_label[lo] != 0) break;
         if (steps >= N_BACKOFF) begin
            res.err = 1'b1;
            break;
         end
         acc += arc_weight[lo];
         steps++;
         cur = arc_dest[lo];
      end
      res.steps = steps;
      return res;
   endfunction

   function automatic void apply_load(arc_item_t it);
      if (it.cmd == CMD_STATE) begin
         first_arc[it.st] = it.first;
         state_loaded[it.st] = 1;
      end else if (it.cmd == CMD_ARC) begin
         arc_label[it.slot] = it.lbl;
         arc_dest[it.slot] = it.nst;
         arc_olabel[it.slot] = it.olbl;
         arc_weight[it.slot] = it.wt;
         arc_loaded[it.slot] = 1;
      end
   endfunction

   function automatic logic signed [WT_W-1:0] pick_weight();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      if (roll < 75) return $urandom;
      return roll[0] ? WT_MAX : WT_MIN;
   endfunction

   function automatic bit take_gap();
      if (items_sent >= 400 && items_sent < 900) return 0;
      return $urandom_range(0, 99) < 14;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t: lookup %s got %0d want %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   task automatic send_item(arc_item_t it, bit typed, arc_hit_t want);
      while (take_gap()) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_cmd <= it.cmd;
      req_state <= it.st;
      req_arc_start <= it.first;
      req_arc_slot <= it.slot;
      req_next_state <= it.nst;
      req_in_label <= it.lbl;
      req_out_label <= it.olbl;
      req_weight <= it.wt;
      do @(posedge clock); while (busy);
      if (it.cmd == CMD_QUERY) begin
         pending_lookups.push_back(typed ? want : predict_lookup(it.st, it.lbl));
         lookups_sent++;
      end else begin
         apply_load(it);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_load(cmd_type cmd, int st, int first, int slot, int nst,
                            int lbl, int olbl, logic signed [WT_W-1:0] wt);
      arc_item_t it;
      arc_hit_t  none;
      none = '{default: 0};
      it.cmd = cmd;
      it.st = st;
      it.first = first;
      it.slot = slot;
      it.nst = nst;
      it.lbl = lbl;
      it.olbl = olbl;
      it.wt = wt;
      send_item(it, 0, none);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_lookups.size() > 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, int unsigned val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'(4 * idx);
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_ARCS) arcs_n = val & 32'h7fff;
      else states_n = val & 32'h1fff;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic build_graph(int unsigned arcs_cfg, int unsigned states_cfg,
                              int st_base, int arc_base);
      int lim, aend, pos, st, j, n, lbl, dst;
      settle();
      write_reg(REG_ARCS, arcs_cfg);
      write_reg(REG_STATES, states_cfg);
      lim = (states_n < N_STATES) ? states_n : N_STATES;
      aend = (arcs_n < N_ARCS) ? arcs_n : N_ARCS;
      graph_st_base = st_base;
      graph_arc_base = arc_base;
      pos = arc_base;
      lbl = 1;
      for (st = st_base; st < lim; st++) begin
         if ($urandom_range(0, 4) == 0 || pos >= aend) begin
            send_load(CMD_STATE, st, -1, 0, 0, 0, 0, 0);
            continue;
         end
         send_load(CMD_STATE, st, pos, 0, 0, 0, 0, 0);
         n = $urandom_range(1, 6);
         lbl = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 40);
         for (j = 0; j < n && pos < aend; j++) begin
            dst = (lbl == 0 && $urandom_range(0, 3) == 0) ? st
                : $urandom_range(st_base, lim);
            send_load(CMD_ARC, 0, 0, pos, dst, lbl, $urandom, pick_weight());
            pos++;
            lbl += $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20000 : 40);
         end
      end
      while (pos < aend) begin
         send_load(CMD_ARC, 0, 0, pos, $urandom_range(st_base, lim), lbl, $urandom,
                   pick_weight());
         pos++;
         lbl += $urandom_range(1, 40);
      end
   endtask

   task automatic run_lookups(int n);
      arc_item_t it;
      arc_hit_t  p;
      int        i, roll, lim, aend;
      lim = (states_n < N_STATES) ? states_n : N_STATES;
      aend = (arcs_n < N_ARCS) ? arcs_n : N_ARCS;
      for (i = 0; i < n; i++) begin
         it.cmd = CMD_QUERY;
         it.st = $urandom;
         it.first = $urandom_range(0, 1) ? -1 : $urandom;
         it.slot = $urandom;
         it.nst = $urandom;
         it.lbl = $urandom;
         it.olbl = $urandom;
         it.wt = $urandom;
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            it.cmd = roll[0] ? CMD_STATE : CMD_ARC;
         end else if (roll < 12) begin
            it.cmd = CMD_NONE;
         end else begin
            if ($urandom_range(0, 9) != 0) it.st = $urandom_range(graph_st_base, lim + 1);
            roll = $urandom_range(0, 99);
            if (roll < 60 && aend > graph_arc_base)
               it.lbl = arc_label[$urandom_range(graph_arc_base, aend - 1)];
            else if (roll < 65) it.lbl = 0;
            p = predict_lookup(it.st, it.lbl);
            if (p.undef) continue;
         end
         send_item(it, 0, p);
      end
   endtask

   function automatic void add_row(cmd_type cmd, int st, int first, int slot, int nst,
                                   int lbl, int olbl, logic signed [WT_W-1:0] wt,
                                   bit typed, bit found, int dest, int folbl,
                                   logic signed [WT_W-1:0] twt, int steps, bit err);
      dir_row_t row;
      row.it.cmd = cmd;
      row.it.st = st;
      row.it.first = first;
      row.it.slot = slot;
      row.it.nst = nst;
      row.it.lbl = lbl;
      row.it.olbl = olbl;
      row.it.wt = wt;
      row.typed = typed;
      row.want = '{found, dest, folbl, twt, steps, err, 0};
      dir_rows.push_back(row);
   endfunction

   always @(posedge clock) begin
      arc_hit_t w;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_lookups.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               w = pending_lookups.pop_front();
               if (rsp_found !== w.found) report_mismatch("found", rsp_found, w.found);
               if (rsp_dest_state !== w.dest)
                  report_mismatch("dest_state", rsp_dest_state, w.dest);
               if (rsp_found_out_label !== w.olbl)
                  report_mismatch("out_label", rsp_found_out_label, w.olbl);
               if (rsp_total_weight !== w.wt)
                  report_mismatch("total_weight", rsp_total_weight, w.wt);
               if (rsp_backoff_steps !== w.steps)
                  report_mismatch("backoff_steps", rsp_backoff_steps, w.steps);
               if (rsp_query_error !== w.err)
                  report_mismatch("query_error", rsp_query_error, w.err);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      items_sent = 0;
      lookups_sent = 0;
      arcs_n = 0;
      states_n = 0;
      graph_st_base = 0;
      graph_arc_base = 0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_NONE;
      req_state = '0;
      req_arc_start = '0;
      req_arc_slot = '0;
      req_next_state = '0;
      req_in_label = '0;
      req_out_label = '0;
      req_weight = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // unloaded block: label zero and out-of-range state
      add_row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1);
      add_row(CMD_QUERY, 4095, 0, 0, 0, 65535, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      dir_rows.delete();
      settle();
      write_reg(REG_ARCS, 3);
      write_reg(REG_STATES, 2);

      add_row(CMD_STATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_STATE, 1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_ARC, 0, 0, 0, 0, 0, 0, WT_MAX, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_ARC, 0, 0, 1, 4095, 7, 65535, WT_MAX, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_ARC, 0, 0, 2, 1, 65535, 0, WT_MIN, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1);
      add_row(CMD_QUERY, 0, 0, 0, 0, 65535, 0, 0, 1, 1, 1, 0, WT_MIN, 0, 0);
      add_row(CMD_QUERY, 0, 0, 0, 0, 7, 0, 0, 1, 1, 4095, 65535, WT_MAX, 0, 0);
      // backoff loop on itself runs into the limit
      add_row(CMD_QUERY, 0, 0, 0, 0, 5, 0, 0, 1, 0, 0, 0, 0, N_BACKOFF, 1);
      add_row(CMD_QUERY, 1, 0, 0, 0, 7, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(CMD_QUERY, 4095, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(CMD_NONE, 4095, -1, 16383, 4095, 65535, 65535, -1, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_ARC, 0, 0, 0, 1, 0, 0, WT_MAX, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_QUERY, 0, 0, 0, 0, 5, 0, 0, 1, 0, 0, 0, 0, 1, 0);
      add_row(CMD_STATE, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_QUERY, 0, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_ARC, 0, 0, 2, 1, 65535, 0, WT_MAX, 0, 0, 0, 0, 0, 0, 0);
      // backoff plus arc weight saturates high
      add_row(CMD_QUERY, 0, 0, 0, 0, 65535, 0, 0, 1, 1, 1, 0, WT_MAX, 1, 0);
      add_row(CMD_QUERY, 1, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

      // top states and top arc slots, with both limits past the table sizes
      build_graph(32767, 8191, N_STATES - 8, N_ARCS - 24);
      run_lookups(300);
      build_graph(0, 0, 0, 0);
      run_lookups(30);
      while (items_sent < 1700) begin
         build_graph($urandom_range(1, 200), $urandom_range(1, 48), 0, 0);
         run_lookups(60);
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
